>>> hw/rtl/hrhp_pkg.sv
package hrhp_pkg;

   localparam int OFFSET_BITS_DEFAULT = 16;
   localparam int FIELD_BITS          = 16;
   localparam int KIND_BITS           = 4;
   localparam int POS_BITS            = 5;
   localparam int NUM_HEADERS         = 3;
   localparam int QUEUE_DEPTH         = 4;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_QMARK = 8'h3F;

   localparam logic [POS_BITS-1:0] POS_MAX = '1;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_METHOD,
      PH_TARGET,
      PH_QUERY,
      PH_VERSION,
      PH_HNAME,
      PH_HVALUE
   } phase_type;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_METHOD         = 4'd0,
      KIND_TARGET         = 4'd1,
      KIND_QUERY          = 4'd2,
      KIND_CONTENT_LENGTH = 4'd3,
      KIND_CONTENT_TYPE   = 4'd4,
      KIND_AUTHORIZATION  = 4'd5,
      KIND_BODY_START     = 4'd6,
      KIND_BAD_LINE       = 4'd7,
      KIND_TRUNCATED      = 4'd8
   } kind_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]  kind;
      logic [FIELD_BITS-1:0] start;
      logic [FIELD_BITS-1:0] length;
   } record_type;

   // One accepted byte yields at most two records; 'two' marks the second as present.
   typedef struct packed {
      logic       two;
      record_type rec0;
      record_type rec1;
   } bundle_type;

   localparam logic [0:15][7:0] TEXT_CONTENT_LENGTH = "Content-Length: ";
   localparam logic [0:15][7:0] TEXT_CONTENT_TYPE   = {"Content-Type: ", 16'h0000};
   localparam logic [0:15][7:0] TEXT_AUTHORIZATION  = {"Authorization: ", 8'h00};

   function automatic logic [POS_BITS-1:0] hdr_len(input logic [1:0] k);
      logic [POS_BITS-1:0] len;
      case (k)
         2'd0:    len = 5'd16;
         2'd1:    len = 5'd14;
         2'd2:    len = 5'd15;
         default: len = 5'd0;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] hdr_char(input logic [1:0] k, input logic [3:0] pos);
      logic [7:0] c;
      case (k)
         2'd0:    c = TEXT_CONTENT_LENGTH[pos];
         2'd1:    c = TEXT_CONTENT_TYPE[pos];
         2'd2:    c = TEXT_AUTHORIZATION[pos];
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

>>> hw/rtl/http_request_header_parser_core.sv
// HTTP request head parser.
// Request text enters on the req_ channel one byte per transaction, with
// req_first_byte opening a request and req_final_byte closing it. Each byte
// may produce up to two records on the rsp_ channel: method, target and
// query spans, the value spans of Content-Length, Content-Type and
// Authorization, the body start, or an error record for a bad request line
// or a truncated head. rsp_last_of_run marks the last record of a byte.
// The parser takes one byte per cycle while req_stall is low. With nothing
// queued ahead of it, the accepting edge writes a record into a four-entry
// queue, and from there it is loaded into the rsp_ output register. While the
// receiver does not stall, the output side sends one record per cycle, and a
// byte with two records holds its queue entry until its second record is
// loaded. While the receiver stalls, the output register holds and the queue
// fills; req_stall rises only when the queue is full.
// Reset clears the parse state to idle, empties the queue and drops
// rsp_valid; bytes are ignored until one arrives with req_first_byte set.
module http_request_header_parser_core #(
   parameter int OFFSET_BITS = hrhp_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_data_byte,
   input  logic                            req_first_byte,
   input  logic                            req_final_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [hrhp_pkg::KIND_BITS-1:0]  rsp_field_kind,
   output logic [hrhp_pkg::FIELD_BITS-1:0] rsp_field_start,
   output logic [hrhp_pkg::FIELD_BITS-1:0] rsp_field_length,
   output logic                            rsp_last_of_run
);
   import hrhp_pkg::*;

   logic       in_take;
   logic       push;
   bundle_type push_bundle;
   logic       pop;
   logic       full;
   logic       not_empty;
   bundle_type head;

   assign req_stall = full;
   assign in_take   = req_valid && !full;

   hrhp_front #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_take    (in_take),
      .data_byte  (req_data_byte),
      .first_byte (req_first_byte),
      .final_byte (req_final_byte),
      .push       (push),
      .bundle     (push_bundle)
   );

   hrhp_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (push_bundle),
      .pop         (pop),
      .full        (full),
      .not_empty   (not_empty),
      .head        (head)
   );

   hrhp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .not_empty        (not_empty),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_field_kind   (rsp_field_kind),
      .rsp_field_start  (rsp_field_start),
      .rsp_field_length (rsp_field_length),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule

>>> hw/rtl/hrhp_front.sv
module hrhp_front #(
   parameter int OFFSET_BITS = hrhp_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_take,
   input  logic [7:0]           data_byte,
   input  logic                 first_byte,
   input  logic                 final_byte,
   output logic                 push,
   output hrhp_pkg::bundle_type bundle
);
   import hrhp_pkg::*;

   localparam int WIDE_BITS = OFFSET_BITS + FIELD_BITS + 1;
   localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

   phase_type                  phase_ff, phase_in;
   logic [OFFSET_BITS-1:0]     offset_ff, offset_in;
   logic [OFFSET_BITS-1:0]     span_ff, span_in;
   logic [NUM_HEADERS-1:0]     flags_ff, flags_in;
   logic [POS_BITS-1:0]        pos_ff, pos_in;
   logic [1:0]                 matched_ff, matched_in;
   logic                       cr_ff, cr_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         offset_ff  <= '0;
         span_ff    <= '0;
         flags_ff   <= '1;
         pos_ff     <= '0;
         matched_ff <= '0;
         cr_ff      <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         offset_ff  <= offset_in;
         span_ff    <= span_in;
         flags_ff   <= flags_in;
         pos_ff     <= pos_in;
         matched_ff <= matched_in;
         cr_ff      <= cr_in;
      end
   end

   always_comb begin
      phase_type              phase_e;
      logic [OFFSET_BITS-1:0] off;
      logic [OFFSET_BITS-1:0] span_e;
      logic [NUM_HEADERS-1:0] flags_e;
      logic [POS_BITS-1:0]    pos_e;
      logic [1:0]             matched_e;
      logic                   cr_before;
      logic                   line_end;
      logic                   p_valid;
      logic                   t_valid;
      logic [KIND_BITS-1:0]   p_kind;
      logic [OFFSET_BITS:0]   p_start;
      logic [OFFSET_BITS-1:0] p_len;
      logic [WIDE_BITS-1:0]   start_wide;
      logic [WIDE_BITS-1:0]   len_wide;
      logic [WIDE_BITS-1:0]   off_wide;
      record_type             p_rec;
      record_type             t_rec;

      // A first byte restarts the parse before the byte itself is looked at.
      phase_e   = first_byte ? PH_METHOD : phase_ff;
      off       = first_byte ? '0 : offset_ff;
      span_e    = first_byte ? '0 : span_ff;
      flags_e   = first_byte ? '1 : flags_ff;
      pos_e     = first_byte ? '0 : pos_ff;
      matched_e = first_byte ? '0 : matched_ff;
      cr_before = first_byte ? 1'b0 : cr_ff;
      line_end  = (data_byte == CHAR_LF) && cr_before;

      phase_in   = phase_ff;
      offset_in  = offset_ff;
      span_in    = span_ff;
      flags_in   = flags_ff;
      pos_in     = pos_ff;
      matched_in = matched_ff;
      cr_in      = cr_ff;

      p_valid = 1'b0;
      t_valid = 1'b0;
      p_kind  = KIND_METHOD;
      p_start = '0;
      p_len   = '0;

      if (in_take && (phase_e != PH_IDLE)) begin
         phase_in   = phase_e;
         span_in    = span_e;
         flags_in   = flags_e;
         pos_in     = pos_e;
         matched_in = matched_e;
         cr_in      = (data_byte == CHAR_CR);

         case (phase_e)
            PH_METHOD, PH_TARGET, PH_QUERY: begin
               if ((data_byte == CHAR_CR) || (data_byte == CHAR_LF)) begin
                  p_valid  = 1'b1;
                  p_kind   = KIND_BAD_LINE;
                  p_start  = {1'b0, off};
                  phase_in = PH_IDLE;
               end else if (data_byte == CHAR_SPACE) begin
                  p_valid = 1'b1;
                  case (phase_e)
                     PH_METHOD: p_kind = KIND_METHOD;
                     PH_TARGET: p_kind = KIND_TARGET;
                     default:   p_kind = KIND_QUERY;
                  endcase
                  p_start  = {1'b0, span_e};
                  p_len    = off - span_e;
                  span_in  = off + OFFSET_BITS'(1);
                  phase_in = (phase_e == PH_METHOD) ? PH_TARGET : PH_VERSION;
               end else if ((data_byte == CHAR_QMARK) && (phase_e == PH_TARGET)) begin
                  p_valid  = 1'b1;
                  p_kind   = KIND_TARGET;
                  p_start  = {1'b0, span_e};
                  p_len    = off - span_e;
                  span_in  = off + OFFSET_BITS'(1);
                  phase_in = PH_QUERY;
               end
            end
            PH_VERSION: begin
               if (line_end) begin
                  flags_in   = '1;
                  pos_in     = '0;
                  matched_in = '0;
                  cr_in      = 1'b0;
                  phase_in   = PH_HNAME;
               end
            end
            PH_HNAME: begin
               if (line_end) begin
                  if (pos_e == POS_BITS'(1)) begin
                     // Only the CR came before this LF: the blank line ends the head.
                     p_valid  = 1'b1;
                     p_kind   = KIND_BODY_START;
                     p_start  = {1'b0, off} + (OFFSET_BITS + 1)'(1);
                     phase_in = PH_IDLE;
                  end else begin
                     flags_in   = '1;
                     pos_in     = '0;
                     matched_in = '0;
                     cr_in      = 1'b0;
                  end
               end else begin
                  for (int k = 0; k < NUM_HEADERS; k++) begin
                     if (flags_e[k]) begin
                        if ((pos_e >= hdr_len(2'(k))) ||
                            (hdr_char(2'(k), pos_e[3:0]) != data_byte)) begin
                           flags_in[k] = 1'b0;
                        end else if ((pos_e + POS_BITS'(1)) == hdr_len(2'(k))) begin
                           matched_in = 2'(k + 1);
                        end
                     end
                  end
                  if (pos_e != POS_MAX) begin
                     pos_in = pos_e + POS_BITS'(1);
                  end
                  if (matched_in != 2'd0) begin
                     span_in  = off + OFFSET_BITS'(1);
                     cr_in    = 1'b0;
                     phase_in = PH_HVALUE;
                  end
               end
            end
            PH_HVALUE: begin
               if (line_end) begin
                  p_valid = 1'b1;
                  case (matched_e)
                     2'd1:    p_kind = KIND_CONTENT_LENGTH;
                     2'd2:    p_kind = KIND_CONTENT_TYPE;
                     default: p_kind = KIND_AUTHORIZATION;
                  endcase
                  p_start    = {1'b0, span_e};
                  p_len      = off - span_e - OFFSET_BITS'(1);
                  flags_in   = '1;
                  pos_in     = '0;
                  matched_in = '0;
                  cr_in      = 1'b0;
                  phase_in   = PH_HNAME;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase

         if ((phase_in != PH_IDLE) && (final_byte || (off == OFF_MAX))) begin
            t_valid  = 1'b1;
            phase_in = PH_IDLE;
         end
         offset_in = (off == OFF_MAX) ? off : off + OFFSET_BITS'(1);
      end

      start_wide   = WIDE_BITS'(p_start);
      len_wide     = WIDE_BITS'(p_len);
      off_wide     = WIDE_BITS'(off);
      p_rec.kind   = p_kind;
      p_rec.start  = start_wide[FIELD_BITS-1:0];
      p_rec.length = len_wide[FIELD_BITS-1:0];
      t_rec.kind   = KIND_TRUNCATED;
      t_rec.start  = off_wide[FIELD_BITS-1:0];
      t_rec.length = '0;

      push        = p_valid || t_valid;
      bundle.two  = p_valid && t_valid;
      bundle.rec0 = p_valid ? p_rec : t_rec;
      bundle.rec1 = t_rec;
   end

   // A final byte always leaves the parser halted.
   assert property (@(posedge clock) disable iff (reset)
      in_take && final_byte |=> phase_ff == PH_IDLE)
      else $error("parser still active after a final byte");

   // A halted parser without a first byte produces nothing.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) && !first_byte |-> !push)
      else $error("record produced while the parser is halted");

endmodule

>>> hw/rtl/hrhp_queue.sv
module hrhp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  hrhp_pkg::bundle_type push_bundle,
   input  logic                 pop,
   output logic                 full,
   output logic                 not_empty,
   output hrhp_pkg::bundle_type head
);
   import hrhp_pkg::*;

   localparam int PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   bundle_type              entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_bundle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_BITS'(1);
      end
   end

   assign full      = (count_ff == COUNT_BITS'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

   assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("write into a full queue");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("read from an empty queue");

   assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + COUNT_BITS'(1))
      else $error("queue fill level lost a write");

endmodule

>>> hw/rtl/hrhp_back.sv
module hrhp_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  not_empty,
   input  hrhp_pkg::bundle_type                  head,
   output logic                                  pop,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [hrhp_pkg::KIND_BITS-1:0]        rsp_field_kind,
   output logic [hrhp_pkg::FIELD_BITS-1:0]       rsp_field_start,
   output logic [hrhp_pkg::FIELD_BITS-1:0]       rsp_field_length,
   output logic                                  rsp_last_of_run
);
   import hrhp_pkg::*;

   logic       valid_ff, valid_in;
   logic       second_ff, second_in;
   record_type rec_ff, rec_in;
   logic       last_ff, last_in;
   logic       load;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff  <= rec_in;
      last_ff <= last_in;
   end

   // The head bundle is sent one record at a time; it leaves the queue with its last record.
   always_comb begin
      load      = not_empty && (!valid_ff || !rsp_stall);
      rec_in    = rec_ff;
      last_in   = last_ff;
      second_in = second_ff;
      pop       = 1'b0;
      valid_in  = valid_ff && rsp_stall;
      if (load) begin
         rec_in    = second_ff ? head.rec1 : head.rec0;
         last_in   = second_ff || !head.two;
         pop       = last_in;
         second_in = !last_in;
         valid_in  = 1'b1;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_field_kind   = rec_ff.kind;
   assign rsp_field_start  = rec_ff.start;
   assign rsp_field_length = rec_ff.length;
   assign rsp_last_of_run  = last_ff;

endmodule
